/* src/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// shared widths, constants and control types of the trial-division prime test
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int VALUE_W = 32;
  localparam int MAG_W   = VALUE_W - 1;
  localparam int DIV_W   = 17;
  localparam int REM_W   = DIV_W;
  localparam int SQ_W    = 2 * DIV_W;
  localparam int CNT_W   = $clog2(MAG_W);

  localparam logic [DIV_W-1:0] DIV_THREE = DIV_W'(3);
  localparam logic [DIV_W-1:0] DIV_FIRST = DIV_W'(5);
  localparam logic [DIV_W-1:0] DIV_PAIR  = DIV_W'(2);
  localparam logic [DIV_W-1:0] DIV_STEP  = DIV_W'(6);
  localparam logic [MAG_W-1:0] MAG_ONE   = MAG_W'(1);
  localparam logic [MAG_W-1:0] MAG_TWO   = MAG_W'(2);
  localparam logic [MAG_W-1:0] MAG_THREE = MAG_W'(3);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAG_W - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLASS = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_SQ    = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    SEL_THREE = 2'd0,
    SEL_D     = 2'd1,
    SEL_D2    = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     d_init;
    logic     d_adv;
    logic     sq_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_step;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic le_one;
    logic two_three;
    logic even;
    logic div_last;
    logic rem_zero;
    logic sq_gt;
  } stat_t;

endpackage

`default_nettype wire

/* src/ptd_dp.sv */
// ----------------------------------------------------------------------------
// ptd_dp
// operand registers, wheel divisor, square compare and bit-serial remainder
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_dp (
  input  wire logic                        clk,
  input  wire logic [ptd_pkg::VALUE_W-1:0] in_value,
  input  wire ptd_pkg::cmd_t               cmd,
  output ptd_pkg::stat_t                   stat
);

  logic [ptd_pkg::MAG_W-1:0] x_r;
  logic                      neg_r;
  logic [ptd_pkg::DIV_W-1:0] d_r;
  logic [ptd_pkg::DIV_W-1:0] div_r;
  logic [ptd_pkg::MAG_W-1:0] sh_r;
  logic [ptd_pkg::REM_W-1:0] rem_r;
  logic [ptd_pkg::CNT_W-1:0] cnt_r;
  logic [ptd_pkg::SQ_W-1:0]  sq_r;

  logic [ptd_pkg::REM_W:0]   rem_sh;
  logic [ptd_pkg::REM_W:0]   rem_nxt;
  logic [ptd_pkg::DIV_W-1:0] div_nxt;

  always_comb begin
    rem_sh = {rem_r, sh_r[ptd_pkg::MAG_W-1]};
    if (rem_sh >= {1'b0, div_r}) begin
      rem_nxt = rem_sh - {1'b0, div_r};
    end else begin
      rem_nxt = rem_sh;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      ptd_pkg::SEL_THREE: div_nxt = ptd_pkg::DIV_THREE;
      ptd_pkg::SEL_D:     div_nxt = d_r;
      ptd_pkg::SEL_D2:    div_nxt = d_r + ptd_pkg::DIV_PAIR;
      default:            div_nxt = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_value[ptd_pkg::MAG_W-1:0];
      neg_r <= in_value[ptd_pkg::VALUE_W-1];
    end
    if (cmd.d_init) begin
      d_r <= ptd_pkg::DIV_FIRST;
    end else if (cmd.d_adv) begin
      d_r <= d_r + ptd_pkg::DIV_STEP;
    end
    if (cmd.sq_load) begin
      sq_r <= ptd_pkg::SQ_W'(d_r) * ptd_pkg::SQ_W'(d_r);
    end
    if (cmd.div_start) begin
      div_r <= div_nxt;
      sh_r  <= x_r;
      rem_r <= '0;
      cnt_r <= ptd_pkg::CNT_LAST;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt[ptd_pkg::REM_W-1:0];
      sh_r  <= {sh_r[ptd_pkg::MAG_W-2:0], 1'b0};
      cnt_r <= cnt_r - ptd_pkg::CNT_W'(1);
    end
  end

  assign stat.neg       = neg_r;
  assign stat.le_one    = (x_r <= ptd_pkg::MAG_ONE);
  assign stat.two_three = (x_r == ptd_pkg::MAG_TWO) || (x_r == ptd_pkg::MAG_THREE);
  assign stat.even      = ~x_r[0];
  assign stat.div_last  = (cnt_r == '0);
  assign stat.rem_zero  = (rem_r == '0);
  assign stat.sq_gt     = (sq_r > {{(ptd_pkg::SQ_W - ptd_pkg::MAG_W){1'b0}}, x_r});

endmodule

`default_nettype wire

/* src/ptd_ctrl.sv */
// ----------------------------------------------------------------------------
// ptd_ctrl
// sequencer: screening, divisor pair loop, result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire ptd_pkg::stat_t stat,
  output ptd_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                out_valid,
  output logic                out_is_prime
);

  ptd_pkg::state_t   state_r, state_nxt;
  ptd_pkg::div_sel_t sel_r, sel_nxt;
  logic              res_r, res_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    case (state_r)
      ptd_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ptd_pkg::S_CLASS;
        end
      end
      ptd_pkg::S_CLASS: begin
        if (stat.neg || stat.le_one) begin
          res_nxt   = 1'b0;
          state_nxt = ptd_pkg::S_DONE;
        end else if (stat.two_three) begin
          res_nxt   = 1'b1;
          state_nxt = ptd_pkg::S_DONE;
        end else if (stat.even) begin
          res_nxt   = 1'b0;
          state_nxt = ptd_pkg::S_DONE;
        end else begin
          cmd.d_init    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = ptd_pkg::SEL_THREE;
          sel_nxt       = ptd_pkg::SEL_THREE;
          state_nxt     = ptd_pkg::S_DIV;
        end
      end
      ptd_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ptd_pkg::S_CHK;
        end
      end
      ptd_pkg::S_CHK: begin
        if (stat.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = ptd_pkg::S_DONE;
        end else begin
          case (sel_r)
            ptd_pkg::SEL_D: begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = ptd_pkg::SEL_D2;
              sel_nxt       = ptd_pkg::SEL_D2;
              state_nxt     = ptd_pkg::S_DIV;
            end
            ptd_pkg::SEL_D2: begin
              cmd.d_adv = 1'b1;
              state_nxt = ptd_pkg::S_SQ;
            end
            default: begin
              state_nxt = ptd_pkg::S_SQ;
            end
          endcase
        end
      end
      ptd_pkg::S_SQ: begin
        cmd.sq_load = 1'b1;
        state_nxt   = ptd_pkg::S_CMP;
      end
      ptd_pkg::S_CMP: begin
        if (stat.sq_gt) begin
          res_nxt   = 1'b1;
          state_nxt = ptd_pkg::S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = ptd_pkg::SEL_D;
          sel_nxt       = ptd_pkg::SEL_D;
          state_nxt     = ptd_pkg::S_DIV;
        end
      end
      ptd_pkg::S_DONE: begin
        state_nxt = ptd_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ptd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptd_pkg::S_IDLE;
      sel_r   <= ptd_pkg::SEL_THREE;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      res_r   <= res_nxt;
    end
  end

  assign busy         = (state_r != ptd_pkg::S_IDLE);
  assign out_valid    = (state_r == ptd_pkg::S_DONE);
  assign out_is_prime = res_r;

endmodule

`default_nettype wire

/* src/prime_test_trial_division_core.sv */
// ----------------------------------------------------------------------------
// prime_test_trial_division_core
// primality test of a signed 32-bit value by 6k-1 / 6k+1 trial division
// ----------------------------------------------------------------------------
// channel   ports                        handshake
// request   in_value[31:0]               start & !busy
// result    out_is_prime                 out_valid, one cycle, no backpressure
//
// negatives, 0, 1, 2, 3 and even values: decided in the classification state, no division
// otherwise one bit-serial remainder per divisor (3, then each pair)
// busy stays high from the accepted request through the result strobe
// reset returns the sequencer to idle and drops any request in flight
// ----------------------------------------------------------------------------
`default_nettype none

module prime_test_trial_division_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ptd_pkg::VALUE_W-1:0] in_value,
  output logic                             out_valid,
  output logic                             out_is_prime
);

  ptd_pkg::cmd_t  cmd;
  ptd_pkg::stat_t stat;

  ptd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  ptd_dp u_dp (
    .clk      (clk),
    .in_value (in_value),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

/* src/ptd_chk.sv */
// ----------------------------------------------------------------------------
// ptd_chk
// port-level checks of the prime test core
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [ptd_pkg::VALUE_W-1:0] in_value,
  input wire logic                        out_valid,
  input wire logic                        out_is_prime
);

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fast_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_value[ptd_pkg::VALUE_W-1] ||
      (!in_value[0] && (in_value[ptd_pkg::VALUE_W-2:1] != '0) &&
       (in_value != ptd_pkg::VALUE_W'(2)))))
    |-> ##2 (out_valid && !out_is_prime))
    else $error("negative or even value not rejected early");

  a_two_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_value == ptd_pkg::VALUE_W'(2)))
    |-> ##2 (out_valid && out_is_prime))
    else $error("two not reported prime");

endmodule

bind prime_test_trial_division_core ptd_chk u_ptd_chk (.*);

`default_nettype wire

/* sim/prime_test_trial_division_core_tb.sv */
// ----------------------------------------------------------------------------
// prime_test_trial_division_core_tb
// self-checking bench for the trial-division prime test core
// ----------------------------------------------------------------------------
// a directed table covers the classification shortcuts, the signed extremes,
// divisor squares at the edge of the search and the largest positive value;
// rows whose answer is obvious carry it, the rest use the local prime
// predictor. random requests follow, weighted toward cheap values so that
// the run stays short, while negative and large values toggle every bit.
// the sender idles at 33 then 84 then 0 percent; every result strobe is
// checked in order against the expected queue
// ----------------------------------------------------------------------------
`default_nettype none

module prime_test_trial_division_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  VALUE_W       = ptd_pkg::VALUE_W;
  localparam int  DIRECTED_ROWS = 22;
  localparam int  RANDOM_REQS   = 78;
  localparam int  MAX_REPORTS   = 10;
  localparam int  DRAIN_CYCLES  = 16;
  localparam longint CYCLE_LIMIT = 6_000_000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    bit                 known;
    bit                 is_prime;
  } prime_row_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 is_prime;
  } prime_expect_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_is_prime;

  prime_row_t    directed_rows [0:DIRECTED_ROWS-1];
  prime_expect_t verdict_q [$];
  prime_expect_t oldest;

  int     sender_idle_pct;
  int     mismatches;
  int     failures;
  int     results_checked;
  int     primes_expected;
  int     requests_sent;
  longint cycle_count;

  prime_test_trial_division_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // 6k-1 / 6k+1 trial division on the unsigned view of a non-negative value
  function automatic bit trial_division_prime(input logic [VALUE_W-1:0] word);
    longint unsigned x;
    longint unsigned d;
    if (word[VALUE_W-1]) return 1'b0;
    x = longint'(word);
    if (x <= 1) return 1'b0;
    if (x <= 3) return 1'b1;
    if ((x % 2) == 0 || (x % 3) == 0) return 1'b0;
    for (d = 5; d * d <= x; d += 6) begin
      if ((x % d) == 0 || (x % (d + 2)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int pick;
    pick = $urandom_range(0, 99);
    v = $urandom();
    if (pick < 20) begin
      v[VALUE_W-1] = 1'b1;
    end else if (pick < 28) begin
      v[VALUE_W-1] = 1'b0;
      v[0] = 1'b0;
    end else if (pick < 35) begin
      v = VALUE_W'($urandom_range(0, 715827882)) * 3;
    end else if (pick < 40) begin
      v = VALUE_W'($urandom_range(0, 429496729)) * 5;
    end else if (pick < 90) begin
      v = VALUE_W'($urandom_range(0, 65535));
    end else begin
      v = VALUE_W'($urandom_range(65536, 1 << 20));
    end
    return v;
  endfunction

  // called just after a falling edge, returns just after one
  task automatic issue_request(input logic [VALUE_W-1:0] v, input bit known,
                               input bit typed_prime);
    int gap;
    prime_expect_t e;
    gap = 0;
    if ($urandom_range(1, 100) <= sender_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    e.value    = v;
    e.is_prime = known ? typed_prime : trial_division_prime(v);
    if (e.is_prime) primes_expected++;
    verdict_q.push_back(e);
    requests_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, verdict_q.size());
      $display("FAIL prime_test_trial_division_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        failures++;
        if (mismatches < MAX_REPORTS)
          $display("unexpected result is_prime=%b", out_is_prime);
        mismatches++;
      end else begin
        oldest = verdict_q.pop_front();
        results_checked++;
        if (out_is_prime !== oldest.is_prime) begin
          failures++;
          if (mismatches < MAX_REPORTS)
            $display("mismatch value=%0d (0x%08h) is_prime expected %b got %b",
                     $signed(oldest.value), oldest.value, oldest.is_prime,
                     out_is_prime);
          mismatches++;
        end
      end
    end
  end

  initial begin
    start           = 1'b0;
    in_value        = '0;
    rst_n           = 1'b0;
    sender_idle_pct = 33;
    mismatches      = 0;
    failures        = 0;
    results_checked = 0;
    primes_expected = 0;
    requests_sent   = 0;
    cycle_count     = 0;

    directed_rows = '{
      '{32'd0,          1'b1, 1'b0},
      '{32'd1,          1'b1, 1'b0},
      '{32'd2,          1'b1, 1'b1},
      '{32'd3,          1'b1, 1'b1},
      '{32'd4,          1'b1, 1'b0},
      '{32'd6,          1'b1, 1'b0},
      '{32'd9,          1'b1, 1'b0},
      '{32'hFFFF_FFFF,  1'b1, 1'b0},
      '{32'h8000_0000,  1'b1, 1'b0},
      '{32'h7FFF_FFFE,  1'b1, 1'b0},
      '{32'h2AAA_AAAA,  1'b1, 1'b0},
      '{32'd5,          1'b0, 1'b0},
      '{32'd7,          1'b0, 1'b0},
      '{32'd25,         1'b0, 1'b0},
      '{32'd35,         1'b0, 1'b0},
      '{32'd49,         1'b0, 1'b0},
      '{32'd121,        1'b0, 1'b0},
      '{32'd143,        1'b0, 1'b0},
      '{32'd65521,      1'b0, 1'b0},
      '{32'd1000003,    1'b0, 1'b0},
      '{32'h5555_5555,  1'b0, 1'b0},
      '{32'h7FFF_FFFF,  1'b0, 1'b0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].value, directed_rows[i].known,
                    directed_rows[i].is_prime);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) sender_idle_pct = 84;
      if (n == 2 * RANDOM_REQS / 3) sender_idle_pct = 0;
      issue_request(random_value(), 1'b0, 1'b0);
    end
    start <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) failures++;

    $display("checked %0d results from %0d requests (%0d directed, %0d random)",
             results_checked, requests_sent, DIRECTED_ROWS, RANDOM_REQS);
    $display("%0d expected primes, %0d mismatches, %0d cycles",
             primes_expected, mismatches, cycle_count);
    if (failures == 0) begin
      $display("PASS prime_test_trial_division_core");
    end else begin
      $display("FAIL prime_test_trial_division_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* prime_test_trial_division_core.f */
src/ptd_pkg.sv
src/ptd_dp.sv
src/ptd_ctrl.sv
src/prime_test_trial_division_core.sv
src/ptd_chk.sv
sim/prime_test_trial_division_core_tb.sv
